// ===== rtl/hrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_pkg
// Types, character codes and match words shared by the request header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    typedef enum logic [3:0] {
        PH_METHOD       = 4'd0,
        PH_URI          = 4'd1,
        PH_VERSION      = 4'd2,
        PH_CR           = 4'd3,
        PH_LF           = 4'd4,
        PH_NAME         = 4'd5,
        PH_VALUE        = 4'd6,
        PH_FINAL_CR     = 4'd7,
        PH_DONE         = 4'd8,
        PH_FAIL_REQ     = 4'd9,
        PH_FAIL_METHOD  = 4'd10,
        PH_FAIL_NOTIMPL = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY        = 3'd0,
        ST_COMPLETE    = 3'd1,
        ST_BAD_REQUEST = 3'd2,
        ST_BAD_METHOD  = 3'd3,
        ST_NOT_IMPL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TK_NONE  = 2'd0,
        TK_URI   = 2'd1,
        TK_NAME  = 2'd2,
        TK_VALUE = 2'd3
    } token_kind_t;

    localparam int VERSION_CHARS = 8;
    localparam int INDEX_DOC_LEN = 10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_NAME_CTRL_MAX = 8'h21;

    // method and version bytes packed first byte lowest
    localparam logic [31:0] WORD_GET  = 32'h0054_4547;
    localparam logic [31:0] WORD_POST = 32'h5453_4F50;
    localparam logic [31:0] WORD_HEAD = 32'h4441_4548;
    localparam logic [63:0] VER_10    = 64'h302E_312F_5054_5448;
    localparam logic [63:0] VER_11    = 64'h312E_312F_5054_5448;

    typedef struct packed {
        logic blank;
        logic cr;
        logic lf;
        logic slash;
        logic colon;
        logic name_ok;
    } char_class_t;

    typedef struct packed {
        logic [3:0] phase;
        logic [2:0] status;
        logic [1:0] token_kind;
        logic [7:0] token_byte;
        logic       token_end;
        logic       uri_add_index;
    } result_t;

    // header name byte check: controls, space, '!', DEL and the separators
    function automatic logic name_char_ok(input logic [7:0] b);
        logic ok;
        ok = 1'b1;
        if (b <= CH_NAME_CTRL_MAX || b == CH_DEL)
        begin
            ok = 1'b0;
        end
        else
        begin
            // ( ) < > @ , ; : \ " / [ ] ? = { }
            case (b) inside
                8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
                8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D:
                    ok = 1'b0;
                default:
                    ok = 1'b1;
            endcase
        end
        return ok;
    endfunction

endpackage

// ===== rtl/hrp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_req_if
// Request byte channel: valid/ready handshake with byte and start flag.
// ----------------------------------------------------------------------------
interface hrp_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       start_new;

    modport source (output valid, output byte_in, output start_new, input ready);
    modport sink   (input valid, input byte_in, input start_new, output ready);
endinterface

// ===== rtl/hrp_res_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_res_if
// Result channel: valid/ready handshake with phase, status and token fields.
// ----------------------------------------------------------------------------
interface hrp_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] phase;
    logic [2:0] status;
    logic [1:0] token_kind;
    logic [7:0] token_byte;
    logic       token_end;
    logic       uri_add_index;

    modport source (
        output valid, output phase, output status, output token_kind,
        output token_byte, output token_end, output uri_add_index, input ready
    );
    modport sink (
        input valid, input phase, input status, input token_kind,
        input token_byte, input token_end, input uri_add_index, output ready
    );
endinterface

// ===== rtl/hrp_char_class.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_char_class
// Parallel classification of one request byte.
// ----------------------------------------------------------------------------
module hrp_char_class (
    input  logic [7:0]          byte_in,
    output hrp_pkg::char_class_t cls
);
    import hrp_pkg::*;

    always_comb
    begin
        cls.blank   = (byte_in == CH_SPACE) || (byte_in == CH_TAB);
        cls.cr      = (byte_in == CH_CR);
        cls.lf      = (byte_in == CH_LF);
        cls.slash   = (byte_in == CH_SLASH);
        cls.colon   = (byte_in == CH_COLON);
        cls.name_ok = name_char_ok(byte_in);
    end

endmodule

// ===== rtl/hrp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_step
// Parser state and the per-byte phase update with token outputs.
// ----------------------------------------------------------------------------
module hrp_step #(
    parameter int METHOD_LIMIT = 8,
    parameter int URI_LIMIT    = 256,
    parameter int NAME_LIMIT   = 64,
    parameter int VALUE_LIMIT  = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic [7:0]           byte_in,
    input  logic                 start_new,
    input  hrp_pkg::char_class_t cls,
    output hrp_pkg::result_t     result
);
    import hrp_pkg::*;

    localparam int MAX_A   = (METHOD_LIMIT > URI_LIMIT) ? METHOD_LIMIT : URI_LIMIT;
    localparam int MAX_B   = (NAME_LIMIT > VALUE_LIMIT) ? NAME_LIMIT : VALUE_LIMIT;
    localparam int MAX_LIM = (MAX_A > MAX_B) ? MAX_A : MAX_B;
    localparam int CNT_W   = $clog2(MAX_LIM + 1);
    localparam int URI_ADD_MAX = URI_LIMIT - INDEX_DOC_LEN;

    localparam logic [CNT_W-1:0] CNT_ONE     = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_GET     = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_WORD    = CNT_W'(4);
    localparam logic [CNT_W-1:0] CNT_VERSION = CNT_W'(VERSION_CHARS);
    localparam logic [CNT_W-1:0] LIM_METHOD  = CNT_W'(METHOD_LIMIT);
    localparam logic [CNT_W-1:0] LIM_URI     = CNT_W'(URI_LIMIT);
    localparam logic [CNT_W-1:0] LIM_NAME    = CNT_W'(NAME_LIMIT);
    localparam logic [CNT_W-1:0] LIM_VALUE   = CNT_W'(VALUE_LIMIT);
    localparam logic [CNT_W-1:0] LIM_URI_ADD = CNT_W'(URI_ADD_MAX);

    phase_t           phase_reg, phase_next, cur_phase;
    logic [CNT_W-1:0] char_count_reg, char_count_next, cnt;
    logic [31:0]      method_reg, method_next, cur_method;
    logic [63:0]      version_reg, version_next, cur_version;
    logic             last_slash_reg, last_slash_next, cur_slash;
    logic             uri_too_long_doc;
    logic             value_skip;
    token_kind_t      kind;
    logic             tend;
    logic             addidx;

    // start flag discards the old request before this byte
    always_comb
    begin
        cur_phase   = start_new ? PH_METHOD : phase_reg;
        cnt         = start_new ? '0 : char_count_reg;
        cur_method  = start_new ? '0 : method_reg;
        cur_version = start_new ? '0 : version_reg;
        cur_slash   = start_new ? 1'b0 : last_slash_reg;
    end

    assign uri_too_long_doc = cur_slash && (cnt > CNT_ONE) && (cnt > LIM_URI_ADD);
    assign value_skip       = (cnt == '0) && cls.blank;

    // next state
    always_comb
    begin
        phase_next      = cur_phase;
        char_count_next = cnt;
        method_next     = cur_method;
        version_next    = cur_version;
        last_slash_next = cur_slash;
        case (cur_phase)
            PH_METHOD:
            begin
                if (cls.cr || cls.lf)
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
                else if (cls.blank)
                begin
                    if (cnt != '0)
                    begin
                        char_count_next = '0;
                        if (cnt == CNT_WORD &&
                            (cur_method == WORD_POST || cur_method == WORD_HEAD))
                            phase_next = PH_FAIL_NOTIMPL;
                        else if (cnt == CNT_GET && cur_method == WORD_GET)
                            phase_next = PH_URI;
                        else
                            phase_next = PH_FAIL_METHOD;
                    end
                end
                else if (cnt >= LIM_METHOD)
                begin
                    phase_next      = PH_FAIL_METHOD;
                    char_count_next = '0;
                end
                else
                begin
                    if (cnt < CNT_WORD)
                        method_next = cur_method | (32'(byte_in) << {cnt[1:0], 3'b000});
                    char_count_next = cnt + CNT_ONE;
                end
            end
            PH_URI:
            begin
                if (cls.cr || cls.lf)
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
                else if (cls.blank)
                begin
                    if (cnt != '0)
                    begin
                        char_count_next = '0;
                        phase_next      = uri_too_long_doc ? PH_FAIL_REQ : PH_VERSION;
                    end
                end
                else if (cnt >= LIM_URI || (cnt == '0 && !cls.slash))
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
                else
                begin
                    last_slash_next = cls.slash;
                    char_count_next = cnt + CNT_ONE;
                end
            end
            PH_VERSION:
            begin
                if (cls.lf)
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
                else if (!value_skip)
                begin
                    if (cnt < CNT_VERSION)
                    begin
                        if (cls.cr)
                        begin
                            phase_next      = PH_FAIL_REQ;
                            char_count_next = '0;
                        end
                        else
                        begin
                            version_next    = cur_version |
                                              (64'(byte_in) << {cnt[2:0], 3'b000});
                            char_count_next = cnt + CNT_ONE;
                        end
                    end
                    else
                    begin
                        char_count_next = '0;
                        if (cls.cr && (cur_version == VER_10 || cur_version == VER_11))
                            phase_next = PH_CR;
                        else
                            phase_next = PH_FAIL_REQ;
                    end
                end
            end
            PH_CR:
            begin
                phase_next      = cls.lf ? PH_LF : PH_FAIL_REQ;
                char_count_next = '0;
            end
            PH_LF:
            begin
                if (cls.cr)
                begin
                    phase_next      = PH_FINAL_CR;
                    char_count_next = '0;
                end
                else if (cls.name_ok)
                begin
                    phase_next      = PH_NAME;
                    char_count_next = CNT_ONE;
                end
                else
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
            end
            PH_NAME:
            begin
                if (cls.colon)
                begin
                    phase_next      = PH_VALUE;
                    char_count_next = '0;
                end
                else if (cnt < LIM_NAME && cls.name_ok)
                    char_count_next = cnt + CNT_ONE;
                else
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
            end
            PH_VALUE:
            begin
                if (cls.lf)
                begin
                    phase_next      = PH_FAIL_REQ;
                    char_count_next = '0;
                end
                else if (!value_skip)
                begin
                    if (cls.cr)
                    begin
                        phase_next      = PH_CR;
                        char_count_next = '0;
                    end
                    else if (cnt < LIM_VALUE)
                        char_count_next = cnt + CNT_ONE;
                    else
                    begin
                        phase_next      = PH_FAIL_REQ;
                        char_count_next = '0;
                    end
                end
            end
            PH_FINAL_CR:
            begin
                phase_next      = cls.lf ? PH_DONE : PH_FAIL_REQ;
                char_count_next = '0;
            end
            PH_DONE, PH_FAIL_REQ, PH_FAIL_METHOD, PH_FAIL_NOTIMPL:
            begin
                phase_next = cur_phase;
            end
            default:
            begin
                phase_next = PH_FAIL_REQ;
            end
        endcase
    end

    // token outputs
    always_comb
    begin
        kind   = TK_NONE;
        tend   = 1'b0;
        addidx = 1'b0;
        case (cur_phase)
            PH_URI:
            begin
                if (!cls.cr && !cls.lf)
                begin
                    if (cls.blank)
                    begin
                        if (cnt != '0 && !uri_too_long_doc)
                        begin
                            tend   = 1'b1;
                            addidx = cur_slash;
                        end
                    end
                    else if (cnt < LIM_URI && (cnt != '0 || cls.slash))
                        kind = TK_URI;
                end
            end
            PH_LF:
            begin
                if (!cls.cr && cls.name_ok)
                    kind = TK_NAME;
            end
            PH_NAME:
            begin
                if (cls.colon)
                    tend = 1'b1;
                else if (cnt < LIM_NAME && cls.name_ok)
                    kind = TK_NAME;
            end
            PH_VALUE:
            begin
                if (!cls.lf && !value_skip)
                begin
                    if (cls.cr)
                        tend = 1'b1;
                    else if (cnt < LIM_VALUE)
                        kind = TK_VALUE;
                end
            end
            default:
            begin
                kind = TK_NONE;
            end
        endcase
    end

    always_comb
    begin
        result.token_kind    = kind;
        result.token_byte    = (kind != TK_NONE) ? byte_in : 8'd0;
        result.token_end     = tend;
        result.uri_add_index = addidx;
        case (phase_next)
            PH_DONE:
            begin
                result.phase  = PH_DONE;
                result.status = ST_COMPLETE;
            end
            PH_FAIL_REQ:
            begin
                result.phase  = PH_FAIL_REQ;
                result.status = ST_BAD_REQUEST;
            end
            PH_FAIL_METHOD:
            begin
                result.phase  = PH_FAIL_REQ;
                result.status = ST_BAD_METHOD;
            end
            PH_FAIL_NOTIMPL:
            begin
                result.phase  = PH_FAIL_REQ;
                result.status = ST_NOT_IMPL;
            end
            default:
            begin
                result.phase  = phase_next;
                result.status = ST_BUSY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_METHOD;
            char_count_reg <= '0;
            method_reg     <= '0;
            version_reg    <= '0;
            last_slash_reg <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            char_count_reg <= char_count_next;
            method_reg     <= method_next;
            version_reg    <= version_next;
            last_slash_reg <= last_slash_next;
        end
    end

endmodule

// ===== rtl/http_request_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_request_header_parser
// Byte-wide HTTP request line and header parser with token output.
// ----------------------------------------------------------------------------
// a byte is taken into the input register and its result then into the output register
// throughput: one byte per cycle unless stalled, set by the single input and result register
// the parser step is one pass of character classification and phase update
// reset clears handshake state and all parser state to the method phase
module http_request_header_parser #(
    parameter int METHOD_LIMIT = 8,
    parameter int URI_LIMIT    = 256,
    parameter int NAME_LIMIT   = 64,
    parameter int VALUE_LIMIT  = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    hrp_req_if.sink     req,
    hrp_res_if.source   res
);
    import hrp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg;
    result_t     step_res;
    char_class_t cls;
    logic        out_free;
    logic        advance;
    logic        in_take;

    assign out_free  = !out_valid_reg || res.ready;
    assign advance   = in_valid_reg && out_free;
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    hrp_char_class u_class (
        .byte_in (in_byte_reg),
        .cls     (cls)
    );

    hrp_step #(
        .METHOD_LIMIT (METHOD_LIMIT),
        .URI_LIMIT    (URI_LIMIT),
        .NAME_LIMIT   (NAME_LIMIT),
        .VALUE_LIMIT  (VALUE_LIMIT)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .byte_in   (in_byte_reg),
        .start_new (in_start_reg),
        .cls       (cls),
        .result    (step_res)
    );

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= req.byte_in;
            in_start_reg <= req.start_new;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign res.valid         = out_valid_reg;
    assign res.phase         = out_res_reg.phase;
    assign res.status        = out_res_reg.status;
    assign res.token_kind    = out_res_reg.token_kind;
    assign res.token_byte    = out_res_reg.token_byte;
    assign res.token_end     = out_res_reg.token_end;
    assign res.uri_add_index = out_res_reg.uri_add_index;

endmodule

// ===== rtl/hrp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrp_checker
// Port-level checks on the parser result channel, bound to the top level.
// ----------------------------------------------------------------------------
module hrp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] phase,
    input logic [2:0] status,
    input logic [1:0] token_kind,
    input logic [7:0] token_byte,
    input logic       token_end,
    input logic       uri_add_index
);
    import hrp_pkg::*;

    // stalled transaction holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(phase) && $stable(status) &&
        $stable(token_kind) && $stable(token_byte) && $stable(token_end) &&
        $stable(uri_add_index))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((phase == PH_DONE) == (status == ST_COMPLETE)) &&
        ((phase == PH_FAIL_REQ) == (status == ST_BAD_REQUEST ||
        status == ST_BAD_METHOD || status == ST_NOT_IMPL)) &&
        (phase <= PH_FAIL_REQ))
        else $error("phase and status disagree");

    a_token: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != TK_NONE |-> status == ST_BUSY && !token_end &&
        ((token_kind == TK_URI && phase == PH_URI) ||
         (token_kind == TK_NAME && phase == PH_NAME) ||
         (token_kind == TK_VALUE && phase == PH_VALUE)))
        else $error("token byte in wrong phase");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_end |-> token_kind == TK_NONE && token_byte == 8'd0 &&
        (phase == PH_VERSION || phase == PH_VALUE || phase == PH_CR))
        else $error("token end in wrong phase");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && uri_add_index |-> token_end && phase == PH_VERSION)
        else $error("default document flag outside uri end");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .phase         (res.phase),
    .status        (res.status),
    .token_kind    (res.token_kind),
    .token_byte    (res.token_byte),
    .token_end     (res.token_end),
    .uri_add_index (res.uri_add_index)
);
